// File: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg)
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/eul_pkg.sv
// eul_pkg: widths, constants, types and the arctangent table
// shared by all quaternion to euler angle modules; no dependencies
package eul_pkg;

    localparam int TERM_W       = 35;  // product terms, magnitude up to about 2^32
    localparam int NORM_W       = 42;  // normalized coordinates, magnitude below 2^41
    localparam int MAG_W        = 41;
    localparam int CORD_W       = 45;  // cordic coordinates with gain headroom
    localparam int ANG_W        = 28;  // angle accumulator, radians in Q.24
    localparam int OUT_W        = 15;
    localparam int PITCH_W      = 14;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 29;
    localparam int SQ_W         = 58;
    localparam int ROOT_W       = 29;
    localparam int OP_W         = 28;
    localparam int SQRT_LAT     = SQRT_STEPS + 3;
    localparam int ATAN_LAT     = CORDIC_STEPS + 6;

    localparam logic signed [ANG_W-1:0]   PI_Q24    = 28'sd52707179;
    localparam logic signed [TERM_W-1:0]  ONE_Q28   = 35'sd268435456;
    localparam logic signed [OUT_W-1:0]   ANGLE_MAX = 15'sd12868;
    localparam logic signed [PITCH_W-1:0] HALF_PI   = 14'sd6434;

    typedef logic signed [TERM_W-1:0] t_term;

    typedef struct packed {
        t_term roll_y;
        t_term roll_x;
        t_term yaw_y;
        t_term yaw_x;
        t_term pitch_s;
        logic  clamp;
    } t_side;

    // round(atan(2^-i) * 2^24)
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 28'sd13176795;
            1:       v = 28'sd7778716;
            2:       v = 28'sd4110060;
            3:       v = 28'sd2086331;
            4:       v = 28'sd1047214;
            5:       v = 28'sd524117;
            6:       v = 28'sd262123;
            7:       v = 28'sd131069;
            8:       v = 28'sd65536;
            9:       v = 28'sd32768;
            10:      v = 28'sd16384;
            11:      v = 28'sd8192;
            12:      v = 28'sd4096;
            13:      v = 28'sd2048;
            14:      v = 28'sd1024;
            15:      v = 28'sd512;
            16:      v = 28'sd256;
            17:      v = 28'sd128;
            18:      v = 28'sd64;
            19:      v = 28'sd32;
            20:      v = 28'sd16;
            21:      v = 28'sd8;
            22:      v = 28'sd4;
            23:      v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/eul_prod.sv
// eul_prod: two stages forming the quaternion product terms
// depends on eul_pkg
module eul_prod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    input  logic signed [15:0]  i_quat_w,
    output logic                o_valid,
    output eul_pkg::t_side      o_side
);

    localparam int TW = eul_pkg::TERM_W;

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic               r_valid1, r_valid2;
    eul_pkg::t_side     r_side, n_side;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
        end
    end

    // stage 2: doubled sums in q7.28
    always_comb begin
        n_side.roll_y  = (TW'(r_wx) + TW'(r_yz)) <<< 1;
        n_side.roll_x  = eul_pkg::ONE_Q28 - ((TW'(r_xx) + TW'(r_yy)) <<< 1);
        n_side.yaw_y   = (TW'(r_wz) + TW'(r_xy)) <<< 1;
        n_side.yaw_x   = eul_pkg::ONE_Q28 - ((TW'(r_yy) + TW'(r_zz)) <<< 1);
        n_side.pitch_s = (TW'(r_wy) - TW'(r_zx)) <<< 1;
        n_side.clamp   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid2;
    assign o_side  = r_side;

endmodule

// File: rtl/eul_sqrt.sv
// eul_sqrt: pitch clamp test and pipelined integer square root of 2^56 - s^2
// one root bit per stage; carries the other terms alongside; depends on eul_pkg
module eul_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  eul_pkg::t_side                 i_side,
    output logic                           o_valid,
    output eul_pkg::t_side                 o_side,
    output logic [eul_pkg::ROOT_W-1:0]     o_root
);

    localparam int TW    = eul_pkg::TERM_W;
    localparam int SW    = eul_pkg::SQ_W;
    localparam int OW    = eul_pkg::OP_W;
    localparam int STEPS = eul_pkg::SQRT_STEPS;
    localparam int LAT   = eul_pkg::SQRT_LAT;

    logic              r_vld [0:LAT-1];
    eul_pkg::t_side    r_sd  [0:LAT-1];
    logic [OW-1:0]     r_op;
    logic [2*OW-1:0]   r_sq;
    logic [SW-1:0]     r_v   [0:STEPS];
    logic [SW-1:0]     r_r   [1:STEPS];
    logic [TW-1:0]     w_mag;
    logic              w_clamp;
    eul_pkg::t_side    w_side0;

    // stage 1: magnitude of the pitch term and clamp test
    always_comb begin
        w_mag         = i_side.pitch_s[TW-1] ? TW'(-i_side.pitch_s) : TW'(i_side.pitch_s);
        w_clamp       = (w_mag >> OW) != '0;
        w_side0       = i_side;
        w_side0.clamp = w_clamp;
    end

    // valid bits and side terms travel together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= w_side0;
            for (int s = 1; s < LAT; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // stages 1 to 3: operand, square, radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= w_clamp ? '0 : w_mag[OW-1:0];
            r_sq   <= r_op * r_op;
            r_v[0] <= (SW'(1) << (2 * OW)) - SW'(r_sq);
        end
    end

    // restoring root steps, one bit each
    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [SW-1:0] BITV = SW'(1) << (2 * (STEPS - 1 - j));
        logic [SW-1:0] w_res;
        logic [SW-1:0] w_sum;

        if (j == 0) begin : g_first
            assign w_res = '0;
        end else begin : g_next
            assign w_res = r_r[j];
        end
        assign w_sum = w_res + BITV;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_v[j] >= w_sum) begin
                    r_v[j+1] <= r_v[j] - w_sum;
                    r_r[j+1] <= (w_res >> 1) + BITV;
                end else begin
                    r_v[j+1] <= r_v[j];
                    r_r[j+1] <= w_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_side  = r_sd[LAT-1];
    assign o_root  = r_r[STEPS][eul_pkg::ROOT_W-1:0];

endmodule

// File: rtl/eul_atan2.sv
// eul_atan2: pipelined four-quadrant arctangent, cordic in vectoring mode
// quadrant fold, normalizing shift, one cordic step per stage; depends on eul_pkg
module eul_atan2 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  eul_pkg::t_term                     i_y,
    input  eul_pkg::t_term                     i_x,
    output logic                               o_valid,
    output logic signed [eul_pkg::OUT_W-1:0]   o_angle
);

    localparam int TW    = eul_pkg::TERM_W;
    localparam int NW    = eul_pkg::NORM_W;
    localparam int MW    = eul_pkg::MAG_W;
    localparam int CW    = eul_pkg::CORD_W;
    localparam int AW    = eul_pkg::ANG_W;
    localparam int OW    = eul_pkg::OUT_W;
    localparam int STEPS = eul_pkg::CORDIC_STEPS;
    localparam int LAT   = eul_pkg::ATAN_LAT;

    logic                 r_vld  [0:LAT-1];
    logic                 r_zero [0:LAT-2];
    logic signed [AW-1:0] r_fz   [0:4];
    logic signed [NW-1:0] r_x1, r_y1;
    logic signed [NW-1:0] r_nx   [1:4];
    logic signed [NW-1:0] r_ny   [1:4];
    logic [MW-1:0]        r_nm   [1:4];
    logic signed [CW-1:0] r_cx   [1:STEPS];
    logic signed [CW-1:0] r_cy   [1:STEPS];
    logic signed [AW-1:0] r_cz   [1:STEPS];
    logic signed [OW-1:0] r_angle;

    logic signed [NW-1:0] w_x0, w_y0;
    logic signed [AW-1:0] w_z0;
    logic                 w_zero;
    logic signed [NW-1:0] w_ay;
    logic signed [AW-1:0] w_zr;
    logic signed [OW-1:0] w_sat;

    // stage 0: fold the left half plane onto the right
    always_comb begin
        w_zero = (i_x == '0) && (i_y == '0);
        if (i_x[TW-1]) begin
            w_x0 = -NW'(i_x);
            w_y0 = -NW'(i_y);
            w_z0 = i_y[TW-1] ? -eul_pkg::PI_Q24 : eul_pkg::PI_Q24;
        end else begin
            w_x0 = NW'(i_x);
            w_y0 = NW'(i_y);
            w_z0 = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // zero-vector mark and starting angle ride along
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= w_zero;
            for (int s = 1; s < LAT - 1; s++) begin
                r_zero[s] <= r_zero[s-1];
            end
            r_fz[0] <= w_z0;
            for (int s = 1; s < 5; s++) begin
                r_fz[s] <= r_fz[s-1];
            end
        end
    end

    // stage 1: combined magnitude bits for the shift search
    assign w_ay = r_y1[NW-1] ? -r_y1 : r_y1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= w_x0;
            r_y1    <= w_y0;
            r_nx[1] <= r_x1;
            r_ny[1] <= r_y1;
            r_nm[1] <= MW'(r_x1) | MW'(w_ay);
        end
    end

    // stages 2 to 4: normalizing shift, two binary-search steps per stage
    for (genvar n = 1; n < 4; n++) begin : g_norm
        localparam int SA_HI = 1 << (7 - 2 * n);
        localparam int SA_LO = SA_HI / 2;
        logic signed [NW-1:0] w_xa, w_ya, w_xb, w_yb;
        logic [MW-1:0]        w_ma, w_mb;

        always_comb begin
            w_xa = r_nx[n];
            w_ya = r_ny[n];
            w_ma = r_nm[n];
            if ((r_nm[n] >> (MW - SA_HI)) == '0) begin
                w_xa = r_nx[n] <<< SA_HI;
                w_ya = r_ny[n] <<< SA_HI;
                w_ma = r_nm[n] << SA_HI;
            end
            w_xb = w_xa;
            w_yb = w_ya;
            w_mb = w_ma;
            if ((w_ma >> (MW - SA_LO)) == '0) begin
                w_xb = w_xa <<< SA_LO;
                w_yb = w_ya <<< SA_LO;
                w_mb = w_ma << SA_LO;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[n+1] <= w_xb;
                r_ny[n+1] <= w_yb;
                r_nm[n+1] <= w_mb;
            end
        end
    end

    // cordic micro-rotations, one per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        logic signed [CW-1:0] w_xi, w_yi, w_xs, w_ys;
        logic signed [AW-1:0] w_zi;

        if (k == 0) begin : g_first
            assign w_xi = CW'(r_nx[4]);
            assign w_yi = CW'(r_ny[4]);
            assign w_zi = r_fz[4];
        end else begin : g_next
            assign w_xi = r_cx[k];
            assign w_yi = r_cy[k];
            assign w_zi = r_cz[k];
        end
        assign w_xs = w_xi >>> k;
        assign w_ys = w_yi >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_yi[CW-1]) begin
                    r_cx[k+1] <= w_xi + w_ys;
                    r_cy[k+1] <= w_yi - w_xs;
                    r_cz[k+1] <= w_zi + eul_pkg::atan_entry(k);
                end else begin
                    r_cx[k+1] <= w_xi - w_ys;
                    r_cy[k+1] <= w_yi + w_xs;
                    r_cz[k+1] <= w_zi - eul_pkg::atan_entry(k);
                end
            end
        end
    end

    // last stage: round to q3.12 and saturate
    always_comb begin
        w_zr = (r_cz[STEPS] + AW'(2048)) >>> 12;
        if (w_zr > AW'(eul_pkg::ANGLE_MAX)) begin
            w_sat = eul_pkg::ANGLE_MAX;
        end else if (w_zr < -AW'(eul_pkg::ANGLE_MAX)) begin
            w_sat = -eul_pkg::ANGLE_MAX;
        end else begin
            w_sat = w_zr[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[LAT-2] ? '0 : w_sat;
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_angle = r_angle;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// quaternion_to_euler_angles: throughput one beat per cycle while the output beat is not held
// the 24-step cordic and 29-step root pipelines set latency
// whole pipeline holds while the output beat waits; no bubble is squeezed out on a stall
// synchronous active-low reset clears every valid bit; payload registers are not reset
// depends on eul_pkg, eul_prod, eul_sqrt, eul_atan2 and assert_macros.svh
`include "assert_macros.svh"

module quaternion_to_euler_angles (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    input  logic signed [15:0]  i_quat_w,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [14:0]  o_roll_angle,
    output logic signed [13:0]  o_pitch_angle,
    output logic signed [14:0]  o_yaw_angle,
    output logic                o_pitch_clamped
);

    localparam int LAT = eul_pkg::ATAN_LAT;
    localparam int OW  = eul_pkg::OUT_W;
    localparam int PW  = eul_pkg::PITCH_W;
    localparam int TW  = eul_pkg::TERM_W;

    logic                  w_en;
    logic                  w_prod_vld, w_sqrt_vld;
    eul_pkg::t_side        w_prod_side, w_sqrt_side;
    logic [eul_pkg::ROOT_W-1:0] w_root;
    logic                  w_roll_vld, w_yaw_vld, w_pitch_vld;
    logic signed [OW-1:0]  w_roll, w_yaw, w_pitch;
    logic                  r_cl [0:LAT-1];
    logic                  r_ng [0:LAT-1];
    logic                  r_out_valid;
    logic signed [OW-1:0]  r_roll, r_yaw;
    logic signed [PW-1:0]  r_pitch, n_pitch;
    logic                  r_clamped;

    // the whole pipeline advances unless the output beat is held
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    eul_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .o_valid  (w_prod_vld),
        .o_side   (w_prod_side)
    );

    eul_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_prod_vld),
        .i_side  (w_prod_side),
        .o_valid (w_sqrt_vld),
        .o_side  (w_sqrt_side),
        .o_root  (w_root)
    );

    eul_atan2 u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_vld),
        .i_y     (w_sqrt_side.roll_y),
        .i_x     (w_sqrt_side.roll_x),
        .o_valid (w_roll_vld),
        .o_angle (w_roll)
    );

    eul_atan2 u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_vld),
        .i_y     (w_sqrt_side.yaw_y),
        .i_x     (w_sqrt_side.yaw_x),
        .o_valid (w_yaw_vld),
        .o_angle (w_yaw)
    );

    eul_atan2 u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_vld),
        .i_y     (w_sqrt_side.pitch_s),
        .i_x     (eul_pkg::t_term'(TW'(w_root))),
        .o_valid (w_pitch_vld),
        .o_angle (w_pitch)
    );

    // clamp flag and sign follow the arctangent pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cl[0] <= w_sqrt_side.clamp;
            r_ng[0] <= w_sqrt_side.pitch_s[TW-1];
            for (int s = 1; s < LAT; s++) begin
                r_cl[s] <= r_cl[s-1];
                r_ng[s] <= r_ng[s-1];
            end
        end
    end

    // pitch: gimbal-lock override, else limit to a quarter turn
    always_comb begin
        if (r_cl[LAT-1]) begin
            n_pitch = r_ng[LAT-1] ? -eul_pkg::HALF_PI : eul_pkg::HALF_PI;
        end else if (w_pitch > OW'(eul_pkg::HALF_PI)) begin
            n_pitch = eul_pkg::HALF_PI;
        end else if (w_pitch < -OW'(eul_pkg::HALF_PI)) begin
            n_pitch = -eul_pkg::HALF_PI;
        end else begin
            n_pitch = w_pitch[PW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_roll_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll    <= w_roll;
            r_yaw     <= w_yaw;
            r_pitch   <= n_pitch;
            r_clamped <= r_cl[LAT-1];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_clamped;

    // checks
    `AST_ALWAYS(a_lanes_aligned, i_clk, i_rst_n, (w_roll_vld == w_yaw_vld) && (w_roll_vld == w_pitch_vld), "arctangent lanes out of step")
    `AST_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(w_roll_vld) && $stable(w_sqrt_vld), "pipeline moved during stall")
    `AST_IMPLY(a_pitch_range, i_clk, i_rst_n, r_out_valid, (r_pitch <= eul_pkg::HALF_PI) && (r_pitch >= -eul_pkg::HALF_PI), "pitch beyond quarter turn")
    `AST_IMPLY(a_clamp_value, i_clk, i_rst_n, r_out_valid && r_clamped, (r_pitch == eul_pkg::HALF_PI) || (r_pitch == -eul_pkg::HALF_PI), "clamped pitch not at limit")

endmodule

// File: dv/tb_quaternion_to_euler_angles.sv
// tb_quaternion_to_euler_angles: self-checking bench for the quaternion to euler block
// predicts roll, pitch, yaw and clamp flag per beat; depends on the rtl top only
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;

    localparam int  N_STEPS     = 24;
    localparam longint PI_Q24   = 52707179;
    localparam longint ONE_Q28  = 64'sd1 << 28;
    localparam longint NORM_LIM = 64'sd1 << 40;
    localparam longint ANG_MAX  = 12868;
    localparam longint HALF_PI  = 6434;
    localparam int  LATENCY     = 65;
    localparam int  WDOG_LIMIT  = 20000;
    localparam int  N_RANDOM    = 1500;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [14:0] roll;
        logic signed [13:0] pitch;
        logic signed [14:0] yaw;
        logic               clamp;
    } euler_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_quat_x, i_quat_y, i_quat_z, i_quat_w;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [14:0] o_roll_angle;
    logic signed [13:0] o_pitch_angle;
    logic signed [14:0] o_yaw_angle;
    logic               o_pitch_clamped;

    quat_t  quat_q[$];
    euler_t euler_q[$];
    int     n_fail = 0;
    bit     stim_done = 0;
    bit     hold_tx = 0;
    int     idle_cnt = 0;
    int     tx_gap = 0;
    int     rx_gap = 0;

    quaternion_to_euler_angles u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .i_quat_w(i_quat_w),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle(o_yaw_angle), .o_pitch_clamped(o_pitch_clamped)
    );

    // clock
    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // vectoring cordic arctangent, Q.24 accumulator rounded to Q3.12
    function automatic longint cordic_atan2(longint y, longint x);
        longint acc, xs, ys;
        longint tab [N_STEPS] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? PI_Q24 : -PI_Q24;
            x = -x;
            y = -y;
        end
        while ((x < 0 ? -x : x) < NORM_LIM && (y < 0 ? -y : y) < NORM_LIM) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; acc += tab[i];
            end else begin
                x -= ys; y += xs; acc -= tab[i];
            end
        end
        return clip((acc + 2048) >>> 12, ANG_MAX);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t quat_to_euler(quat_t q);
        longint x, y, z, w, s, c;
        euler_t e;
        x = q.x; y = q.y; z = q.z; w = q.w;
        e.roll = 15'(cordic_atan2(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y)));
        e.yaw  = 15'(cordic_atan2(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z)));
        s = 2 * (w * y - z * x);
        if ((s < 0 ? -s : s) >= ONE_Q28) begin
            e.pitch = 14'((s > 0) ? HALF_PI : -HALF_PI);
            e.clamp = 1'b1;
        end else begin
            c = int_sqrt((64'd1 << 56) - longint'(s * s));
            e.pitch = 14'(clip(cordic_atan2(s, c), HALF_PI));
            e.clamp = 1'b0;
        end
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (r < 8) return 16'($urandom);
        return 16'($signed($urandom_range(0, 8)) - 4);
    endfunction

    // random quaternion, mostly near unit length
    function automatic quat_t rand_quat();
        quat_t q;
        real a, b, c, d, n;
        if ($urandom_range(0, 3) == 0) begin
            q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        end else begin
            a = real'($signed($urandom_range(0, 2000)) - 1000);
            b = real'($signed($urandom_range(0, 2000)) - 1000);
            c = real'($signed($urandom_range(0, 2000)) - 1000);
            d = real'($signed($urandom_range(0, 2000)) - 1000);
            n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
            q.x = 16'($rtoi(a * 16384.0 / n));
            q.y = 16'($rtoi(b * 16384.0 / n));
            q.z = 16'($rtoi(c * 16384.0 / n));
            q.w = 16'($rtoi(d * 16384.0 / n));
        end
        return q;
    endfunction

    // stimulus
    initial begin
        quat_q.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        quat_q.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        quat_q.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
        quat_q.push_back('{16'sd0, -16'sd11585, 16'sd0, 16'sd11585});
        quat_q.push_back('{16'sd0, 16'sd11586, 16'sd0, 16'sd11586});
        quat_q.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
        quat_q.push_back('{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192});
        quat_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        quat_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        quat_q.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        quat_q.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        quat_q.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
        quat_q.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        quat_q.push_back('{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
        wait (quat_q.size() == 0);
        // sender holds off until the pipeline has drained
        hold_tx = 1;
        wait (euler_q.size() == 0);
        hold_tx = 0;
        for (int i = 0; i < N_RANDOM; i++) quat_q.push_back(rand_quat());
        wait (quat_q.size() == 0);
        stim_done = 1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the beat
        end else begin
            if (i_in_valid) begin
                euler_q.push_back(quat_to_euler(quat_q.pop_front()));
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (quat_q.size() > 0 && !hold_tx) begin
                i_in_valid <= 1'b1;
                {i_quat_x, i_quat_y, i_quat_z, i_quat_w} <= quat_q[0];
                tx_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        euler_t got, exp_e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_roll_angle, o_pitch_angle, o_yaw_angle, o_pitch_clamped};
                if (euler_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $realtime, got);
                    n_fail++;
                end else begin
                    exp_e = euler_q.pop_front();
                    if (got.roll !== exp_e.roll) begin
                        $display("%0t: roll exp %0d got %0d", $realtime, exp_e.roll, got.roll);
                        n_fail++;
                    end
                    if (got.pitch !== exp_e.pitch) begin
                        $display("%0t: pitch exp %0d got %0d", $realtime, exp_e.pitch,
                                 got.pitch);
                        n_fail++;
                    end
                    if (got.yaw !== exp_e.yaw) begin
                        $display("%0t: yaw exp %0d got %0d", $realtime, exp_e.yaw, got.yaw);
                        n_fail++;
                    end
                    if (got.clamp !== exp_e.clamp) begin
                        $display("%0t: clamp exp %0b got %0b", $realtime, exp_e.clamp,
                                 got.clamp);
                        n_fail++;
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                rx_gap <= pick_gap();
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // reset and end of run
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        {i_quat_x, i_quat_y, i_quat_z, i_quat_w} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        @(posedge i_clk);
        wait (euler_q.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
